>>> hw/rtl/srrt_pkg.sv
// shared types and constants for the selective-repeat receive tracker
// no dependencies
package srrt_pkg;

  localparam int MaxPackets = 4096;
  localparam int MaxNacks   = 64;
  localparam int SeqW       = $clog2(MaxPackets);
  localparam int CntW       = $clog2(MaxPackets + 1);
  localparam int ByteW      = 28;
  localparam int BlkW       = 16;
  localparam int LimW       = 7;
  localparam int QDepth     = 4;
  localparam int QAw        = 2;

  typedef enum logic [1:0] {
    KIND_NEW  = 2'd0,
    KIND_DUP  = 2'd1,
    KIND_OOR  = 2'd2,
    KIND_NACK = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_BLOCK = 2'd0,
    REG_FILE  = 2'd1,
    REG_TOTAL = 2'd2,
    REG_LIMIT = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ARR_RD,
    ST_ARR_DO,
    ST_SCAN_RD,
    ST_SCAN_DO
  } state_t;

  // one classified item from the front to the back
  typedef struct packed {
    logic            timeout;
    logic [SeqW-1:0] seq;
    logic            oor;
    logic [ByteW-1:0] off;
    logic [BlkW-1:0] len;
  } cmd_t;

  typedef struct packed {
    kind_t            kind;
    logic [SeqW-1:0]  seq;
    logic [ByteW-1:0] off;
    logic [BlkW-1:0]  len;
    logic [ByteW-1:0] bytes;
    logic [CntW-1:0]  pkts;
    logic             done;
    logic             last;
  } res_t;

endpackage

>>> hw/rtl/srrt_ram.sv
// generic single-port-write, single-read ram with registered read data
// no dependencies
module srrt_ram #(
  parameter int Width = 1,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/srrt_front.sv
// front part: accepts items, computes offset and length, classifies range
// depends on srrt_pkg
module srrt_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [srrt_pkg::SeqW-1:0]      in_seq,
  input  logic [srrt_pkg::BlkW-1:0]      block_size,
  input  logic [srrt_pkg::ByteW-1:0]     file_size,
  input  logic [srrt_pkg::CntW-1:0]      top,
  output logic                           q_valid,
  input  logic                           q_ready,
  output srrt_pkg::cmd_t                 q_cmd
);
  // stage 1 registers the multiply, stage 2 classifies
  logic                          s1_v_r;
  logic                          s1_op_r;
  logic [srrt_pkg::SeqW-1:0]     s1_seq_r;
  logic [srrt_pkg::SeqW+srrt_pkg::BlkW-1:0] s1_off_r;
  logic                          s2_v_r;
  srrt_pkg::cmd_t                s2_r, s2_nxt;
  logic                          adv2, adv1;
  logic [srrt_pkg::SeqW+srrt_pkg::BlkW:0] rem;

  assign adv2     = !s2_v_r || q_ready;
  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;
  assign q_valid  = s2_v_r;
  assign q_cmd    = s2_r;

  always_comb begin
    s2_nxt         = '0;
    s2_nxt.timeout = s1_op_r;
    s2_nxt.seq     = s1_seq_r;
    rem = {{(srrt_pkg::SeqW+srrt_pkg::BlkW+1-srrt_pkg::ByteW){1'b0}}, file_size}
          - {1'b0, s1_off_r};
    if (!s1_op_r) begin
      if ({1'b0, s1_seq_r} >= top) begin
        s2_nxt.oor = 1'b1;
      end else if ({1'b0, s1_seq_r} + 1'b1 == top) begin
        if (rem[srrt_pkg::SeqW+srrt_pkg::BlkW]) begin
          s2_nxt.oor = 1'b1;
        end else begin
          s2_nxt.off = s1_off_r[srrt_pkg::ByteW-1:0];
          s2_nxt.len = (rem > {{(srrt_pkg::SeqW+1){1'b0}}, block_size}) ? block_size
                       : rem[srrt_pkg::BlkW-1:0];
        end
      end else begin
        s2_nxt.off = s1_off_r[srrt_pkg::ByteW-1:0];
        s2_nxt.len = block_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_valid;
      if (adv2) s2_v_r <= s1_v_r;
    end
    if (adv1) begin
      s1_op_r  <= in_op;
      s1_seq_r <= in_seq;
      s1_off_r <= in_seq * block_size;
    end
    if (adv2) s2_r <= s2_nxt;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !q_ready |=> s2_v_r && $stable(s2_r)) else $error("front stage lost");
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_r.oor |-> s2_r.len == '0 && s2_r.off == '0) else $error("oor payload");
  a_to: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_r.timeout |-> !s2_r.oor) else $error("timeout flagged oor");
endmodule

>>> hw/rtl/srrt_queue.sv
// short fifo of classified items between front and back
// depends on srrt_pkg
module srrt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  srrt_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output srrt_pkg::cmd_t rd_cmd
);
  srrt_pkg::cmd_t mem_r [srrt_pkg::QDepth];
  logic [srrt_pkg::QAw-1:0] wp_r, rp_r;
  logic [srrt_pkg::QAw:0]   cnt_r;
  logic push, pop;

  assign wr_ready = cnt_r != (srrt_pkg::QAw+1)'(srrt_pkg::QDepth);
  assign rd_valid = cnt_r != '0;
  assign rd_cmd   = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{srrt_pkg::QAw{1'b0}}, push} - {{srrt_pkg::QAw{1'b0}}, pop};
    end
    if (push) mem_r[wp_r] <= wr_cmd;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (srrt_pkg::QAw+1)'(srrt_pkg::QDepth)) else $error("queue overflow");
endmodule

>>> hw/rtl/srrt_back.sv
// back part: bitmap update, counters and nack scan
// depends on srrt_pkg and srrt_ram
module srrt_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  srrt_pkg::cmd_t             q_cmd,
  input  logic [srrt_pkg::ByteW-1:0] file_size,
  input  logic [srrt_pkg::CntW-1:0]  top,
  input  logic [srrt_pkg::LimW-1:0]  nack_limit,
  output logic                       res_valid,
  input  logic                       res_ready,
  output srrt_pkg::res_t             res
);
  srrt_pkg::state_t st_r, st_nxt;
  srrt_pkg::cmd_t   cmd_r;
  logic [srrt_pkg::SeqW:0]    ptr_r, ptr_nxt;
  logic [srrt_pkg::LimW-1:0]  n_r, n_nxt, lim;
  logic [srrt_pkg::ByteW-1:0] bytes_r, bytes_nxt;
  logic [srrt_pkg::CntW-1:0]  pkts_r, pkts_nxt;
  logic                       done_r, done_nxt;
  logic                       ov_r, ov_nxt;
  srrt_pkg::res_t             out_r, out_nxt;
  logic [srrt_pkg::SeqW-1:0]  pend_r, pend_nxt;
  logic                       pend_v_r, pend_v_nxt;
  logic                       we, wd, rd;
  logic [srrt_pkg::SeqW-1:0]  wa, ra;
  logic [srrt_pkg::ByteW:0]   sum;
  logic                       out_free;

  srrt_ram #(.Width(1), .Depth(srrt_pkg::MaxPackets)) u_map (
    .clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd));

  assign res_valid = ov_r;
  assign res       = out_r;
  assign out_free  = !ov_r || res_ready;

  always_comb begin
    lim = (nack_limit == '0) ? srrt_pkg::LimW'(1)
        : (nack_limit > srrt_pkg::LimW'(srrt_pkg::MaxNacks)) ? srrt_pkg::LimW'(srrt_pkg::MaxNacks)
        : nack_limit;
    sum = {1'b0, bytes_r} + {{(srrt_pkg::ByteW-srrt_pkg::BlkW+1){1'b0}}, cmd_r.len};
  end

  always_comb begin
    st_nxt     = st_r;
    ptr_nxt    = ptr_r;
    n_nxt      = n_r;
    bytes_nxt  = bytes_r;
    pkts_nxt   = pkts_r;
    done_nxt   = done_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    ov_nxt     = ov_r && !res_ready;
    out_nxt    = out_r;
    q_ready    = 1'b0;
    we         = 1'b0;
    wa         = ptr_r[srrt_pkg::SeqW-1:0];
    wd         = 1'b0;
    ra         = ptr_r[srrt_pkg::SeqW-1:0];
    case (st_r)
      srrt_pkg::ST_CLEAR: begin
        we = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == (srrt_pkg::SeqW+1)'(srrt_pkg::MaxPackets - 1)) st_nxt = srrt_pkg::ST_IDLE;
      end
      srrt_pkg::ST_IDLE: begin
        q_ready = out_free;
        ra = q_cmd.seq;
        if (q_valid && out_free) begin
          if (q_cmd.timeout) begin
            ptr_nxt = '0;
            n_nxt = '0;
            pend_v_nxt = 1'b0;
            st_nxt = srrt_pkg::ST_SCAN_RD;
          end else if (q_cmd.oor) begin
            ov_nxt = 1'b1;
            out_nxt = '{kind: srrt_pkg::KIND_OOR, seq: q_cmd.seq, off: '0, len: '0,
                        bytes: bytes_r, pkts: pkts_r, done: done_r, last: 1'b1};
          end else begin
            st_nxt = srrt_pkg::ST_ARR_DO;
          end
        end
      end
      srrt_pkg::ST_ARR_DO: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          st_nxt = srrt_pkg::ST_IDLE;
          if (rd) begin
            out_nxt = '{kind: srrt_pkg::KIND_DUP, seq: cmd_r.seq, off: '0, len: '0,
                        bytes: bytes_r, pkts: pkts_r, done: done_r, last: 1'b1};
          end else begin
            we = 1'b1;
            wa = cmd_r.seq;
            wd = 1'b1;
            pkts_nxt = pkts_r + 1'b1;
            bytes_nxt = sum[srrt_pkg::ByteW] ? '1 : sum[srrt_pkg::ByteW-1:0];
            done_nxt = done_r || (bytes_nxt >= file_size);
            out_nxt = '{kind: srrt_pkg::KIND_NEW, seq: cmd_r.seq, off: cmd_r.off,
                        len: cmd_r.len, bytes: bytes_nxt, pkts: pkts_nxt,
                        done: done_nxt, last: 1'b1};
          end
        end
      end
      srrt_pkg::ST_SCAN_RD: begin
        // issue read of ptr; data arrives next cycle
        if (ptr_r >= top || n_r == lim) begin
          if (pend_v_r) begin
            if (out_free) begin
              ov_nxt = 1'b1;
              out_nxt = '{kind: srrt_pkg::KIND_NACK, seq: pend_r, off: '0, len: '0,
                          bytes: bytes_r, pkts: pkts_r, done: done_r, last: 1'b1};
              pend_v_nxt = 1'b0;
              st_nxt = srrt_pkg::ST_IDLE;
            end
          end else begin
            st_nxt = srrt_pkg::ST_IDLE;
          end
        end else begin
          st_nxt = srrt_pkg::ST_SCAN_DO;
        end
      end
      srrt_pkg::ST_SCAN_DO: begin
        if (rd) begin
          ptr_nxt = ptr_r + 1'b1;
          st_nxt = srrt_pkg::ST_SCAN_RD;
        end else if (!pend_v_r || out_free) begin
          // a found entry is held back until the next one shows it is not last
          if (pend_v_r) begin
            ov_nxt = 1'b1;
            out_nxt = '{kind: srrt_pkg::KIND_NACK, seq: pend_r, off: '0, len: '0,
                        bytes: bytes_r, pkts: pkts_r, done: done_r, last: 1'b0};
          end
          pend_v_nxt = 1'b1;
          pend_nxt = ptr_r[srrt_pkg::SeqW-1:0];
          n_nxt = n_r + 1'b1;
          ptr_nxt = ptr_r + 1'b1;
          st_nxt = srrt_pkg::ST_SCAN_RD;
        end
      end
      default: st_nxt = srrt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= srrt_pkg::ST_CLEAR;
      ptr_r    <= '0;
      n_r      <= '0;
      bytes_r  <= '0;
      pkts_r   <= '0;
      done_r   <= 1'b0;
      ov_r     <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      ptr_r    <= ptr_nxt;
      n_r      <= n_nxt;
      bytes_r  <= bytes_nxt;
      pkts_r   <= pkts_nxt;
      done_r   <= done_nxt;
      ov_r     <= ov_nxt;
      pend_v_r <= pend_v_nxt;
    end
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
    if (q_valid && q_ready) cmd_r <= q_cmd;
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && st_r != srrt_pkg::ST_CLEAR |=> done_r) else $error("done dropped");
  a_nack_lim: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= srrt_pkg::LimW'(srrt_pkg::MaxNacks)) else $error("nack count over limit");
  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == srrt_pkg::ST_CLEAR |-> !q_ready) else $error("item taken during clear");
endmodule

>>> hw/rtl/selective_repeat_receive_tracker.sv
// selective-repeat receive tracker: an arrival passes the front stage registers, the queue
// and the back's bitmap read to the result register (out of range skips the read); the back
// takes a new arrival only after the bitmap ram read-then-update of the last one
// timeout: a read state and a check state per bitmap entry scanned, up to the window top or the nack limit
// reset: synchronous; a clearing pass over all 4096 entries zeroes the bitmap, during
// which the front still takes up to six items that wait; config writes are taken as ever
module selective_repeat_receive_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op[0], seq_in[12:1], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [103:0] out_tdata, // kind[1:0] seq_out[13:2] write_offset[41:14]
                                  // write_length[57:42] bytes_received[85:58]
                                  // packets_received[98:86] done_res[99] zero fill
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [srrt_pkg::BlkW-1:0]  block_r;
  logic [srrt_pkg::ByteW-1:0] file_r;
  logic [srrt_pkg::CntW-1:0]  total_r, top;
  logic [srrt_pkg::LimW-1:0]  limit_r;
  logic fq_v, fq_r, bq_v, bq_r;
  srrt_pkg::cmd_t fq_c, bq_c;
  srrt_pkg::res_t res;
  logic wr;
  srrt_pkg::reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = srrt_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign top = (total_r > srrt_pkg::CntW'(srrt_pkg::MaxPackets))
               ? srrt_pkg::CntW'(srrt_pkg::MaxPackets) : total_r;

  always_comb begin
    case (idx)
      srrt_pkg::REG_BLOCK: cfg_prdata = {16'd0, block_r};
      srrt_pkg::REG_FILE:  cfg_prdata = {4'd0, file_r};
      srrt_pkg::REG_TOTAL: cfg_prdata = {19'd0, total_r};
      srrt_pkg::REG_LIMIT: cfg_prdata = {25'd0, limit_r};
      default:             cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_r <= 16'd1024;
      file_r  <= '0;
      total_r <= '0;
      limit_r <= 7'd64;
    end else if (wr) begin
      case (idx)
        srrt_pkg::REG_BLOCK: block_r <= cfg_pwdata[15:0];
        srrt_pkg::REG_FILE:  file_r  <= cfg_pwdata[27:0];
        srrt_pkg::REG_TOTAL: total_r <= cfg_pwdata[12:0];
        srrt_pkg::REG_LIMIT: limit_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  srrt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_op(in_tdata[0]), .in_seq(in_tdata[12:1]), .block_size(block_r),
    .file_size(file_r), .top(top), .q_valid(fq_v), .q_ready(fq_r), .q_cmd(fq_c));

  srrt_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(fq_v), .wr_ready(fq_r), .wr_cmd(fq_c),
    .rd_valid(bq_v), .rd_ready(bq_r), .rd_cmd(bq_c));

  srrt_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(bq_v), .q_ready(bq_r), .q_cmd(bq_c),
    .file_size(file_r), .top(top), .nack_limit(limit_r),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res));

  assign out_tdata = {4'd0, res.done, res.pkts, res.bytes, res.len, res.off,
                      res.seq, res.kind};
  assign out_tlast = res.last;
endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// testbench for the selective-repeat receive tracker: stream driver and monitor
// with a behavioral predictor, apb register setup per phase; needs srrt_pkg
module tb;

  typedef struct {
    bit        op;
    bit [11:0] seq;
  } pkt_item_t;

  typedef struct {
    srrt_pkg::kind_t kind;
    bit [11:0] seq;
    bit [27:0] off;
    bit [15:0] len;
    bit [27:0] bytes;
    bit [12:0] pkts;
    bit        done;
    bit        last;
  } track_res_t;

  localparam int DrainCycles = 2 * srrt_pkg::MaxPackets + 64;
  localparam int WatchLimit  = 60000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;  // op[0], seq_in[12:1], zero fill
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [103:0] out_tdata;     // kind, seq_out, write_offset, write_length,
                               // bytes_received, packets_received, done_res
  logic out_tlast;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  selective_repeat_receive_tracker u_dut (.*);

  // tracker state mirror
  bit [15:0] blk_size;
  bit [27:0] file_bytes;
  bit [12:0] pkt_total;
  bit [6:0]  nack_max;
  bit        rx_map[srrt_pkg::MaxPackets];
  bit [27:0] byte_cnt;
  bit [12:0] pkt_cnt;
  bit        xfer_done;

  pkt_item_t  send_q[$];
  track_res_t tracker_exp_q[$];
  int snd_idle = 0;
  int rcv_stall = 0;
  int errors = 0;
  int watch = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void push_res(srrt_pkg::kind_t k, bit [11:0] s, bit [27:0] o,
                                   bit [15:0] l, bit lst);
    track_res_t r;
    r.kind = k; r.seq = s; r.off = o; r.len = l;
    r.bytes = byte_cnt; r.pkts = pkt_cnt; r.done = xfer_done; r.last = lst;
    tracker_exp_q.push_back(r);
  endfunction

  function automatic void track_item(pkt_item_t it);
    int unsigned top;
    int unsigned lim;
    int n;
    longint unsigned off;
    longint unsigned len;
    longint unsigned sum;
    top = (pkt_total > srrt_pkg::MaxPackets) ? srrt_pkg::MaxPackets : pkt_total;
    if (it.op == 1'b0) begin
      if (it.seq >= top) begin
        push_res(srrt_pkg::KIND_OOR, it.seq, 28'd0, 16'd0, 1'b1);
        return;
      end
      off = longint'(it.seq) * longint'(blk_size);
      len = blk_size;
      if (it.seq + 1 == top) begin
        if (off > file_bytes) begin
          push_res(srrt_pkg::KIND_OOR, it.seq, 28'd0, 16'd0, 1'b1);
          return;
        end
        len = file_bytes - off;
        if (len > blk_size) len = blk_size;
      end
      if (rx_map[it.seq]) begin
        push_res(srrt_pkg::KIND_DUP, it.seq, 28'd0, 16'd0, 1'b1);
        return;
      end
      rx_map[it.seq] = 1'b1;
      pkt_cnt = pkt_cnt + 1;
      sum = byte_cnt + len;
      byte_cnt = (sum > 28'hFFFFFFF) ? 28'hFFFFFFF : sum[27:0];
      if (byte_cnt >= file_bytes) xfer_done = 1'b1;
      push_res(srrt_pkg::KIND_NEW, it.seq, off[27:0], len[15:0], 1'b1);
    end else begin
      lim = (nack_max == 0) ? 1 : (nack_max > srrt_pkg::MaxNacks) ? srrt_pkg::MaxNacks
          : nack_max;
      n = 0;
      for (int j = 0; j < top && n < lim; j++) begin
        if (!rx_map[j]) begin
          push_res(srrt_pkg::KIND_NACK, j[11:0], 28'd0, 16'd0, 1'b0);
          n++;
        end
      end
      if (n > 0) tracker_exp_q[$].last = 1'b1;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      track_item(send_q.pop_front());
    end
    if (in_tvalid && !in_tready) begin
      in_tvalid <= 1'b1;
    end else if (send_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
      in_tvalid <= 1'b1;
      in_tdata <= {3'b000, send_q[0].seq, send_q[0].op};
    end else begin
      in_tvalid <= 1'b0;
    end
    out_tready <= ($urandom_range(99) >= rcv_stall);
  end

  // monitor
  always @(posedge clk) begin
    track_res_t e;
    track_res_t a;
    if (out_tvalid && out_tready) begin
      a.kind = srrt_pkg::kind_t'(out_tdata[1:0]);
      a.seq = out_tdata[13:2];
      a.off = out_tdata[41:14];
      a.len = out_tdata[57:42];
      a.bytes = out_tdata[85:58];
      a.pkts = out_tdata[98:86];
      a.done = out_tdata[99];
      a.last = out_tlast;
      if (tracker_exp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", a);
      end else begin
        e = tracker_exp_q.pop_front();
        if (a.kind != e.kind || a.seq != e.seq || a.off != e.off || a.len != e.len ||
            a.bytes != e.bytes || a.pkts != e.pkts || a.done != e.done ||
            a.last != e.last) begin
          errors++;
          if (errors <= 10) $display("mismatch: exp %p got %p", e, a);
        end
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      watch <= 0;
    end else if (watch >= WatchLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      watch <= watch + 1;
    end
  end

  task automatic reg_write(srrt_pkg::reg_idx_t idx, bit [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      srrt_pkg::REG_BLOCK: blk_size = val[15:0];
      srrt_pkg::REG_FILE:  file_bytes = val[27:0];
      srrt_pkg::REG_TOTAL: pkt_total = val[12:0];
      srrt_pkg::REG_LIMIT: nack_max = val[6:0];
      default: ;
    endcase
  endtask

  task automatic setup(bit [15:0] bs, bit [27:0] fs, bit [12:0] tp, bit [6:0] nl);
    reg_write(srrt_pkg::REG_BLOCK, {16'd0, bs});
    reg_write(srrt_pkg::REG_FILE, {4'd0, fs});
    reg_write(srrt_pkg::REG_TOTAL, {19'd0, tp});
    reg_write(srrt_pkg::REG_LIMIT, {25'd0, nl});
  endtask

  task automatic add_item(bit op, bit [11:0] seq);
    pkt_item_t it;
    it.op = op;
    it.seq = seq;
    send_q.push_back(it);
  endtask

  // mostly arrivals near the window, some anywhere, a few timeouts
  task automatic add_random(int n);
    int unsigned top;
    int unsigned r;
    int unsigned hi;
    top = (pkt_total > srrt_pkg::MaxPackets) ? srrt_pkg::MaxPackets : pkt_total;
    hi = (top + 1 > 4095) ? 4095 : top + 1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 9) add_item(1'b1, 12'($urandom_range(4095)));
      else if (r < 84) add_item(1'b0, 12'($urandom_range(hi)));
      else add_item(1'b0, 12'($urandom_range(4095)));
    end
  endtask

  task automatic drain();
    while (send_q.size() != 0 || tracker_exp_q.size() != 0) @(posedge clk);
    // a timeout with nothing missing may still be scanning
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_idle(int mode);
    case (mode)
      1: begin snd_idle = 54; rcv_stall = 0; end
      2: begin snd_idle = 0; rcv_stall = 54; end
      3: begin snd_idle = 29; rcv_stall = 29; end
      default: begin snd_idle = 0; rcv_stall = 0; end
    endcase
  endtask

  initial begin
    blk_size = 16'd1024; file_bytes = '0; pkt_total = '0; nack_max = 7'd64;
    byte_cnt = '0; pkt_cnt = '0; xfer_done = 1'b0;
    foreach (rx_map[i]) rx_map[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty window, arrival is out of range, timeout gives nothing
    add_item(1'b0, 12'd0);
    add_item(1'b1, 12'hFFF);
    drain();

    setup(16'd100, 28'd950, 13'd10, 7'd3);
    add_item(1'b0, 12'd0);
    add_item(1'b0, 12'd0);
    add_item(1'b0, 12'd9);
    add_item(1'b0, 12'd10);
    add_item(1'b0, 12'hFFF);
    add_item(1'b1, 12'd0);
    add_random(30);
    drain();

    // zero block size, nack limit zero
    set_idle(1);
    setup(16'd0, 28'd0, 13'd20, 7'd0);
    add_item(1'b0, 12'd15);
    add_item(1'b1, 12'd0);
    add_random(45);
    drain();

    // last packet of zero length, limit above the maximum
    set_idle(2);
    setup(16'd100, 28'd2900, 13'd30, 7'd127);
    add_item(1'b0, 12'd29);
    add_item(1'b1, 12'd0);
    add_random(45);
    drain();

    // last packet beyond the file end
    set_idle(3);
    setup(16'd100, 28'd500, 13'd40, 7'd5);
    add_item(1'b0, 12'd39);
    add_random(45);
    drain();

    // largest sizes, window clamped to the bitmap; sender holds off midway
    set_idle(0);
    setup(16'hFFFF, 28'd268431360, 13'h1FFF, 7'd64);
    add_item(1'b0, 12'hFFF);
    add_item(1'b0, 12'd0);
    add_item(1'b1, 12'd0);
    add_random(60);
    while (send_q.size() != 0 || tracker_exp_q.size() != 0) @(posedge clk);
    set_idle(3);
    add_random(60);
    drain();

    set_idle(1);
    setup(16'd1, 28'd0, 13'd4096, 7'd1);
    add_random(50);
    drain();

    set_idle(2);
    setup(16'd512, 28'd30000, 13'd60, 7'd8);
    add_random(50);
    drain();

    set_idle(0);
    setup(16'd1024, 28'd100000, 13'd100, 7'd64);
    add_random(40);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
